// File: hdl/osm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osm_pkg: shared types and constants of the order-statistic multiset
// Field widths, request and status codes, and the command and status groups
// that join the controller to the datapath.
// ----------------------------------------------------------------------------
package osm_pkg;

    // Field widths
    localparam int VALUE_W  = 32;
    localparam int RANK_W   = 9;
    localparam int STATUS_W = 2;

    // Query read tree: cells per first-level group
    localparam int GRP_BITS = 4;
    localparam int GRP_SIZE = 1 << GRP_BITS;

    // Request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic ins;    // insert beat accepted: shift the cell chain
        logic qload;  // query beat accepted: load the group registers
        logic pick;   // select the final cell into the stage register
        logic push;   // move the stage register into the output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_query;  // request type of the beat on the input channel
    } t_stat;

endpackage
`default_nettype wire

// File: hdl/osm_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osm_req_if: request channel of the order-statistic multiset
// Valid/ready handshake carrying the request type, value and rank.
// ----------------------------------------------------------------------------
interface osm_req_if;
    import osm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic signed [VALUE_W-1:0]  value;
    logic        [RANK_W-1:0]   rank;

    modport source (output valid, req_type, value, rank, input ready);
    modport sink   (input valid, req_type, value, rank, output ready);
endinterface
`default_nettype wire

// File: hdl/osm_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osm_rsp_if: response channel of the order-statistic multiset
// Valid/ready handshake carrying the result value and status.
// ----------------------------------------------------------------------------
interface osm_rsp_if;
    import osm_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [VALUE_W-1:0]   result_value;
    logic        [STATUS_W-1:0]  status;

    modport source (output valid, result_value, status, input ready);
    modport sink   (input valid, result_value, status, output ready);
endinterface
`default_nettype wire

// File: hdl/osm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osm_ctrl: controller of the order-statistic multiset
// Sequences insert and query beats and owns the output valid flag.
// ----------------------------------------------------------------------------
module osm_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    input  wire            i_out_ready,
    output logic           o_out_valid,
    input  osm_pkg::t_stat i_stat,
    output osm_pkg::t_cmd  o_cmd
);
    import osm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PICK,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;
    logic   w_accept;

    // Output slot frees when empty or drained this cycle
    assign w_out_free = !r_out_valid || i_out_ready;

    // Take a new beat when idle, or when the staged result leaves now; hold off in reset
    assign o_in_ready  = i_rst_n
                         && ((r_state == S_IDLE) || ((r_state == S_DONE) && w_out_free));
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    // Issue datapath commands
    always_comb begin
        o_cmd.ins   = w_accept && !i_stat.is_query;
        o_cmd.qload = w_accept && i_stat.is_query;
        o_cmd.pick  = (r_state == S_PICK);
        o_cmd.push  = (r_state == S_DONE) && w_out_free;
    end

    // Next state and output valid
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = i_stat.is_query ? S_PICK : S_DONE;
                end
            end
            S_PICK: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    if (w_accept) begin
                        n_state = i_stat.is_query ? S_PICK : S_DONE;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (o_cmd.push) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Hold state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule
`default_nettype wire

// File: hdl/osm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// osm_datapath: sorted cell chain and query read tree
// Each cell compares the incoming value with its own entry and shifts up on
// insert; a query reads one cell through a two-level registered mux.
// ----------------------------------------------------------------------------
module osm_datapath #(
    parameter int CAPACITY = 256
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  osm_pkg::t_cmd                        i_cmd,
    output osm_pkg::t_stat                       o_stat,
    input  wire                                  i_req_type,
    input  wire signed [osm_pkg::VALUE_W-1:0]    i_value,
    input  wire        [osm_pkg::RANK_W-1:0]     i_rank,
    output logic signed [osm_pkg::VALUE_W-1:0]   o_result_value,
    output logic        [osm_pkg::STATUS_W-1:0]  o_status
);
    import osm_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RD = (CAPACITY < (1 << RANK_W)) ? CAPACITY : (1 << RANK_W);
    localparam int NG = (RD + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GW = (NG > 1) ? $clog2(NG) : 1;
    localparam int XW = (CW > RANK_W) ? CW : RANK_W;

    logic signed [VALUE_W-1:0]  r_cell [CAPACITY];
    logic signed [VALUE_W-1:0]  n_cell [CAPACITY];
    logic [CAPACITY-1:0]        w_gt;
    logic [CW-1:0]              r_count;
    logic                       w_full;

    logic [RANK_W-1:0]          w_idx;
    logic signed [VALUE_W-1:0]  r_grp [NG];
    logic signed [VALUE_W-1:0]  n_grp [NG];
    logic [GW-1:0]              r_gsel;
    logic                       r_qbad;
    logic                       n_qbad;

    logic signed [VALUE_W-1:0]  r_stage_val;
    logic [STATUS_W-1:0]        r_stage_st;
    logic signed [VALUE_W-1:0]  r_out_val;
    logic [STATUS_W-1:0]        r_out_st;

    assign o_stat.is_query = (i_req_type == REQ_QUERY);
    assign w_full          = (r_count == CW'(CAPACITY));

    // Per-cell compare: entry is live and larger than the new value
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_gt[i] = (CW'(i) < r_count) && (r_cell[i] > i_value);
        end
    end

    // Shift larger entries up one cell, drop the value into the gap
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            if ((i > 0) && w_gt[(i > 0) ? i - 1 : 0]) begin
                n_cell[i] = r_cell[(i > 0) ? i - 1 : 0];
            end else if (w_gt[i] || (CW'(i) == r_count)) begin
                n_cell[i] = i_value;
            end else begin
                n_cell[i] = r_cell[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins && !w_full) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_cell[i] <= n_cell[i];
            end
        end
    end

    // Count stored values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.ins && !w_full) begin
            r_count <= r_count + CW'(1);
        end
    end

    // First mux level: one cell per group by the low index bits
    assign w_idx  = i_rank - RANK_W'(1);
    assign n_qbad = (i_rank == '0) || (XW'(i_rank) > XW'(r_count));

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n_grp[g] = '0;
            for (int j = 0; j < GRP_SIZE; j++) begin
                if (((g * GRP_SIZE + j) < CAPACITY)
                        && (w_idx[GRP_BITS-1:0] == GRP_BITS'(j))) begin
                    n_grp[g] = r_cell[((g * GRP_SIZE + j) < CAPACITY) ?
                                      (g * GRP_SIZE + j) : 0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.qload) begin
            for (int g = 0; g < NG; g++) begin
                r_grp[g] <= n_grp[g];
            end
            r_gsel <= w_idx[GRP_BITS +: GW];
            r_qbad <= n_qbad;
        end
    end

    // Stage the result of the current beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins) begin
            r_stage_val <= '0;
            r_stage_st  <= w_full ? ST_FULL : ST_OK;
        end else if (i_cmd.pick) begin
            r_stage_val <= r_qbad ? '0 : r_grp[r_gsel];
            r_stage_st  <= r_qbad ? ST_RANGE : ST_OK;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_val <= r_stage_val;
            r_out_st  <= r_stage_st;
        end
    end

    assign o_result_value = r_out_val;
    assign o_status       = r_out_st;
endmodule
`default_nettype wire

// File: hdl/order_statistic_multiset.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// order_statistic_multiset: sorted multiset with k-th smallest queries
//
//   channel  dir  payload                        handshake
//   i_req    in   req_type, value, rank          valid / ready
//   o_rsp    out  result_value, status           valid / ready
//
// An insert beat shifts the sorted cell chain in the cycle it is accepted;
// inserts sustain one beat per cycle while the output is not stalled.
// A query beat loads the group registers at accept, then the final mux fills the stage register.
// Reset clears the count and the controller and holds ready low; cells are don't-care.
// A result waits in the output register while the next beat is worked on;
// a stalled output holds the input off once the stage register is full.
// ----------------------------------------------------------------------------
module order_statistic_multiset #(
    parameter int CAPACITY = 256
) (
    input  wire     i_clk,
    input  wire     i_rst_n,
    osm_req_if.sink   i_req,
    osm_rsp_if.source o_rsp
);
    import osm_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    osm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    osm_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_req_type     (i_req.req_type),
        .i_value        (i_req.value),
        .i_rank         (i_req.rank),
        .o_result_value (o_rsp.result_value),
        .o_status       (o_rsp.status)
    );

`ifndef SYNTHESIS
    // A query beat always proceeds to the final mux next cycle
    a_query_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.qload |=> w_cmd.pick)
        else $error("query did not reach final select");

    // No beat is taken while the final mux is busy
    a_pick_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.pick |-> !i_req.ready)
        else $error("input accepted during final select");

    // A pushed result shows up on the output next cycle
    a_push_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push |=> o_rsp.valid)
        else $error("pushed result not valid");

    // Results with an error status carry a zero value
    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != ST_OK)) |-> (o_rsp.result_value == '0))
        else $error("nonzero value on error status");
`endif
endmodule
`default_nettype wire
